>>> hdl/tvc_pkg.sv
package tvc_pkg;

   localparam int SETS       = 128;
   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 32;
   localparam int SET_BITS   = $clog2(SETS);

   localparam int REQ_DATA_BITS = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((VALUE_BITS + 7) / 8) * 8;
   localparam int CMD_BITS      = 2;
   localparam int STATUS_BITS   = 3;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_LOOKUP = 2'd0,
      CMD_FILL   = 2'd1,
      CMD_WRITE  = 2'd2,
      CMD_FLUSH  = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_HIT         = 3'd0,
      ST_MISS        = 3'd1,
      ST_FILLED      = 3'd2,
      ST_WR_CACHED   = 3'd3,
      ST_WR_UNCACHED = 3'd4,
      ST_FLUSHED     = 3'd5
   } status_type;

   typedef logic [SET_BITS-1:0]   set_type;
   typedef logic [KEY_BITS-1:0]   key_type;
   typedef logic [VALUE_BITS-1:0] value_type;

   // Access to one way's key and value memories.
   typedef struct packed {
      logic      rd_en;
      set_type   rd_set;
      logic      wr_key_en;
      logic      wr_value_en;
      set_type   wr_set;
      key_type   wr_key;
      value_type wr_value;
   } mem_req_type;

   typedef struct packed {
      key_type   key;
      value_type value;
   } mem_entry_type;

   // Update of the per-set valid and recently-used bits.
   typedef struct packed {
      logic    flush;
      logic    set_valid0;
      logic    set_valid1;
      logic    set_recent;
      logic    recent_way;
      set_type set_index;
   } set_upd_type;

   typedef struct packed {
      logic valid0;
      logic valid1;
      logic recent;
   } set_info_type;

endpackage

>>> hdl/tvc_way_mem.sv
module tvc_way_mem (
   input  logic                   clock,
   input  tvc_pkg::mem_req_type   req,
   output tvc_pkg::mem_entry_type rd_entry_ff
);

   tvc_pkg::key_type   key_mem   [tvc_pkg::SETS];
   tvc_pkg::value_type value_mem [tvc_pkg::SETS];

   always_ff @(posedge clock) begin
      if (req.wr_key_en) begin
         key_mem[req.wr_set] <= req.wr_key;
      end
      if (req.wr_value_en) begin
         value_mem[req.wr_set] <= req.wr_value;
      end
   end

   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         rd_entry_ff.key   <= key_mem[req.rd_set];
         rd_entry_ff.value <= value_mem[req.rd_set];
      end
   end

endmodule

>>> hdl/tvc_set_state.sv
module tvc_set_state (
   input  logic                  clock,
   input  logic                  reset,
   input  tvc_pkg::set_type      rd_set,
   input  tvc_pkg::set_upd_type  upd,
   output tvc_pkg::set_info_type info
);

   logic [tvc_pkg::SETS-1:0] valid0_ff, valid0_in;
   logic [tvc_pkg::SETS-1:0] valid1_ff, valid1_in;
   logic [tvc_pkg::SETS-1:0] recent_ff, recent_in;

   always_comb begin
      valid0_in = valid0_ff;
      valid1_in = valid1_ff;
      recent_in = recent_ff;
      if (upd.flush) begin
         valid0_in = '0;
         valid1_in = '0;
      end
      if (upd.set_valid0) begin
         valid0_in[upd.set_index] = 1'b1;
      end
      if (upd.set_valid1) begin
         valid1_in[upd.set_index] = 1'b1;
      end
      if (upd.set_recent) begin
         recent_in[upd.set_index] = upd.recent_way;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= '0;
         valid1_ff <= '0;
         recent_ff <= '0;
      end else begin
         valid0_ff <= valid0_in;
         valid1_ff <= valid1_in;
         recent_ff <= recent_in;
      end
   end

   assign info.valid0 = valid0_ff[rd_set];
   assign info.valid1 = valid1_ff[rd_set];
   assign info.recent = recent_ff[rd_set];

   // A flush leaves no way valid anywhere.
   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      upd.flush |=> (valid0_ff == '0) && (valid1_ff == '0))
      else $error("flush left a valid way");

endmodule

>>> hdl/two_way_value_cache.sv
// Channel  Direction  Ports                 Contents
// req      in         req_tvalid/tready     tuser: cmd; tdata: key, data
// rsp      out        rsp_tvalid/tready     tuser: status; tdata: value
//
// The ways' memories are read when a request is accepted, and the compare and
// write-back happen in the lookup stage once the response register is free.
// A new request is taken once the previous one has left the lookup stage.
// Reset invalidates all ways at once and needs no sweep.
// A stalled response holds the lookup stage; one more request can be taken
// while a response waits.
module two_way_value_cache (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [tvc_pkg::CMD_BITS-1:0]      req_tuser,   // cmd
   input  logic [tvc_pkg::REQ_DATA_BITS-1:0] req_tdata,   // key, data
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [tvc_pkg::STATUS_BITS-1:0]   rsp_tuser,   // status
   output logic [tvc_pkg::RSP_DATA_BITS-1:0] rsp_tdata    // value
);

   logic req_fire;
   logic s1_done;

   logic                 s1_valid_ff, s1_valid_in;
   tvc_pkg::cmd_type     s1_cmd_ff;
   tvc_pkg::key_type     s1_key_ff;
   tvc_pkg::value_type   s1_data_ff;
   tvc_pkg::set_type     s1_set;

   logic                 out_valid_ff, out_valid_in;
   tvc_pkg::status_type  out_status_ff, out_status_in;
   tvc_pkg::value_type   out_value_ff, out_value_in;

   tvc_pkg::mem_req_type   mem0_req, mem1_req;
   tvc_pkg::mem_entry_type mem0_entry, mem1_entry;
   tvc_pkg::set_upd_type   set_upd;
   tvc_pkg::set_info_type  set_info;

   logic raw_hit0, raw_hit1, hit0, hit1;
   logic fill_way;

   assign req_tready = !s1_valid_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign s1_done    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign s1_set     = s1_key_ff[tvc_pkg::SET_BITS-1:0];

   tvc_way_mem u_way0 (
      .clock       (clock),
      .req         (mem0_req),
      .rd_entry_ff (mem0_entry)
   );

   tvc_way_mem u_way1 (
      .clock       (clock),
      .req         (mem1_req),
      .rd_entry_ff (mem1_entry)
   );

   tvc_set_state u_set_state (
      .clock  (clock),
      .reset  (reset),
      .rd_set (s1_set),
      .upd    (set_upd),
      .info   (set_info)
   );

   // Way 0 wins if both ways ever matched.
   assign raw_hit0 = set_info.valid0 && (mem0_entry.key == s1_key_ff);
   assign raw_hit1 = set_info.valid1 && (mem1_entry.key == s1_key_ff);
   assign hit0     = raw_hit0;
   assign hit1     = raw_hit1 && !raw_hit0;
   // A fill reuses a matching way, otherwise replaces the way that is not recent.
   assign fill_way = hit0 ? 1'b0 : (hit1 ? 1'b1 : !set_info.recent);

   always_comb begin
      mem0_req             = '0;
      mem1_req             = '0;
      mem0_req.rd_en       = req_fire;
      mem1_req.rd_en       = req_fire;
      mem0_req.rd_set      = req_tdata[tvc_pkg::SET_BITS-1:0];
      mem1_req.rd_set      = req_tdata[tvc_pkg::SET_BITS-1:0];
      mem0_req.wr_set      = s1_set;
      mem1_req.wr_set      = s1_set;
      mem0_req.wr_key      = s1_key_ff;
      mem1_req.wr_key      = s1_key_ff;
      mem0_req.wr_value    = s1_data_ff;
      mem1_req.wr_value    = s1_data_ff;

      set_upd              = '0;
      set_upd.set_index    = s1_set;

      out_status_in        = out_status_ff;
      out_value_in         = out_value_ff;

      if (s1_done) begin
         out_value_in = '0;
         case (s1_cmd_ff)
            tvc_pkg::CMD_LOOKUP: begin
               if (hit0 || hit1) begin
                  out_status_in      = tvc_pkg::ST_HIT;
                  out_value_in       = hit0 ? mem0_entry.value : mem1_entry.value;
                  set_upd.set_recent = 1'b1;
                  set_upd.recent_way = hit1;
               end else begin
                  out_status_in = tvc_pkg::ST_MISS;
               end
            end
            tvc_pkg::CMD_FILL: begin
               mem0_req.wr_key_en   = !fill_way;
               mem0_req.wr_value_en = !fill_way;
               mem1_req.wr_key_en   = fill_way;
               mem1_req.wr_value_en = fill_way;
               set_upd.set_valid0   = !fill_way;
               set_upd.set_valid1   = fill_way;
               set_upd.set_recent   = 1'b1;
               set_upd.recent_way   = fill_way;
               out_status_in        = tvc_pkg::ST_FILLED;
            end
            tvc_pkg::CMD_WRITE: begin
               mem0_req.wr_value_en = hit0;
               mem1_req.wr_value_en = hit1;
               out_status_in = (hit0 || hit1) ? tvc_pkg::ST_WR_CACHED
                                              : tvc_pkg::ST_WR_UNCACHED;
            end
            default: begin
               set_upd.flush = 1'b1;
               out_status_in = tvc_pkg::ST_FLUSHED;
            end
         endcase
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_done) begin
         s1_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (s1_done) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cmd_ff  <= tvc_pkg::cmd_type'(req_tuser);
         s1_key_ff  <= req_tdata[tvc_pkg::KEY_BITS-1:0];
         s1_data_ff <= req_tdata[tvc_pkg::KEY_BITS +: tvc_pkg::VALUE_BITS];
      end
      out_status_ff <= out_status_in;
      out_value_ff  <= out_value_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tdata  = tvc_pkg::RSP_DATA_BITS'(out_value_ff);

   a_accept_loads_stage: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_valid_ff)
      else $error("accepted request did not reach the lookup stage");

   a_stage_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_valid_ff && !rsp_tready) |=> s1_valid_ff && $stable(s1_key_ff))
      else $error("lookup stage lost its request during a stall");

   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> !(raw_hit0 && raw_hit1))
      else $error("key found in both ways of a set");

   a_value_zero_unless_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != tvc_pkg::ST_HIT)) |-> (out_value_ff == '0))
      else $error("nonzero value on a response that is not a hit");

endmodule
